### src/lru_page_replacement_unit_assert.svh
// assertion macros for the lru page replacement unit
// expects clk and rst_n in the scope where the macros are used
`ifndef LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH

// same-cycle implication
`define LRU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lru_pr_pkg.sv
// shared constants, types and helpers for the lru page replacement unit
// no dependencies
package lru_pr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_W     = 10;
  localparam int CNT_W      = 5;

  localparam logic [CNT_W-1:0] FRAME_COUNT_RST = CNT_W'(4);

  // broadcast to every cell of the stack
  typedef struct packed {
    logic              load;
    logic [PAGE_W-1:0] page;
  } cell_ctl_t;

  // frames actually usable for a programmed frame count
  function automatic logic [CNT_W-1:0] cap_of(input logic [CNT_W-1:0] fc);
    logic [CNT_W-1:0] c;
    c = fc;
    if (fc == '0) c = CNT_W'(1);
    else if (fc > CNT_W'(MAX_FRAMES)) c = CNT_W'(MAX_FRAMES);
    return c;
  endfunction

endpackage

### src/lru_page_replacement_unit.sv
// top level of the lru page replacement unit: chain of stack cells plus
// fill count, frame count register and result registers; uses lru_pr_pkg,
// lru_pr_cell and lru_page_replacement_unit_assert.svh
//
//   port group   direction  handshake                 payload
//   request      in         start && !busy            in_page_number
//   result       out        out_valid (one cycle)     out_hit, out_evicted_valid,
//                                                     out_evicted_page
//   config       in         cfg_we                    cfg_wdata
//
// one request per cycle: the cell compare, the match chain and the shift all
// settle in the cycle the request is taken, so busy stays low
// the result is registered and shows in the cycle after the request is taken
// synchronous active-low reset empties the stack and sets frame count to 4
// writing the frame count empties the stack without reporting evictions
// the receiver cannot stall
module lru_page_replacement_unit
  import lru_pr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [PAGE_W-1:0] in_page_number,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic              out_hit,
  output logic              out_evicted_valid,
  output logic [PAGE_W-1:0] out_evicted_page
);

  logic [CNT_W-1:0]  frame_count_r, frame_count_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic              out_ev_valid_r, out_ev_valid_nxt;
  logic [PAGE_W-1:0] out_ev_page_r, out_ev_page_nxt;

  logic              accept;
  logic [CNT_W-1:0]  cap;
  logic              full;
  logic              hit;
  logic              evict;
  logic [CNT_W-1:0]  limit;
  cell_ctl_t         ctl;

  logic [MAX_FRAMES:0]   prior;
  logic [PAGE_W-1:0]     pages  [MAX_FRAMES];
  logic [PAGE_W-1:0]     ev_pg  [MAX_FRAMES];
  logic [PAGE_W-1:0]     ev_or  [MAX_FRAMES+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cap    = cap_of(frame_count_r);
  assign full   = (used_r == cap);
  assign hit    = prior[MAX_FRAMES];
  assign evict  = !hit && full;
  // deepest cell that shifts on a miss
  assign limit  = full ? used_r - CNT_W'(1) : used_r;

  assign ctl.load = accept;
  assign ctl.page = in_page_number;

  assign prior[0] = 1'b0;
  assign ev_or[0] = '0;

  for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
    logic [PAGE_W-1:0] up;
    logic              shift_en;
    logic              valid;
    logic              ev_sel;

    if (k == 0) begin : g_head
      assign up = in_page_number;
    end else begin : g_body
      assign up = pages[k-1];
    end

    assign valid    = CNT_W'(k) < used_r;
    // on a hit shift down to the matching cell, on a miss down to the limit
    assign shift_en = hit ? !prior[k] : (CNT_W'(k) <= limit);
    assign ev_sel   = evict && (CNT_W'(k) == used_r - CNT_W'(1));

    lru_pr_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .up_page  (up),
      .valid    (valid),
      .shift_en (shift_en),
      .ev_sel   (ev_sel),
      .prior_in (prior[k]),
      .prior_out(prior[k+1]),
      .page     (pages[k]),
      .ev_page  (ev_pg[k])
    );

    assign ev_or[k+1] = ev_or[k] | ev_pg[k];
  end

  always_comb begin
    frame_count_nxt = frame_count_r;
    used_nxt        = used_r;
    if (accept && !hit && !full) used_nxt = used_r + CNT_W'(1);
    if (cfg_we) begin
      frame_count_nxt = cfg_wdata;
      used_nxt        = '0;
    end
  end

  always_comb begin
    out_valid_nxt    = accept;
    out_hit_nxt      = out_hit_r;
    out_ev_valid_nxt = out_ev_valid_r;
    out_ev_page_nxt  = out_ev_page_r;
    if (accept) begin
      out_hit_nxt      = hit;
      out_ev_valid_nxt = evict;
      out_ev_page_nxt  = ev_or[MAX_FRAMES];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RST;
      used_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      frame_count_r <= frame_count_nxt;
      used_r        <= used_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r      <= out_hit_nxt;
    out_ev_valid_r <= out_ev_valid_nxt;
    out_ev_page_r  <= out_ev_page_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;

`include "lru_page_replacement_unit_assert.svh"

  `LRU_ASSERT_NXT(a_strobe, accept, out_valid, "request did not produce a result")
  `LRU_ASSERT_IMP(a_evict_miss, out_valid && out_evicted_valid, !out_hit, "eviction on a hit")
  `LRU_ASSERT_IMP(a_used_bound, 1'b1, used_r <= cap, "fill count above usable frames")
  `LRU_ASSERT_NXT(a_cfg_flush, cfg_we, used_r == '0, "frame count write did not flush")

endmodule

### src/lru_pr_cell.sv
// one entry of the recency stack: holds a page, compares it to the request
// and takes its neighbor's page when the stack shifts; uses lru_pr_pkg
module lru_pr_cell
  import lru_pr_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [PAGE_W-1:0] up_page,
  input  logic              valid,
  input  logic              shift_en,
  input  logic              ev_sel,
  input  logic              prior_in,
  output logic              prior_out,
  output logic [PAGE_W-1:0] page,
  output logic [PAGE_W-1:0] ev_page
);

  logic [PAGE_W-1:0] page_r;
  logic [PAGE_W-1:0] page_nxt;
  logic              match;

  assign match     = valid && (page_r == ctl.page);
  assign prior_out = prior_in | match;
  assign page      = page_r;
  assign ev_page   = ev_sel ? page_r : '0;

  always_comb begin
    page_nxt = page_r;
    if (ctl.load && shift_en) page_nxt = up_page;
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for lru_page_replacement_unit: directed and random page
// requests over several frame counts, checked against a recency-stack predictor
// depends on lru_pr_pkg and the unit's rtl
module testbench;
  import lru_pr_pkg::*;

  typedef struct packed {
    logic              hit;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
  } lru_result_t;

  class lru_scoreboard;
    logic [PAGE_W-1:0] recency [MAX_FRAMES];
    int unsigned       used;
    logic [CNT_W-1:0]  frame_count;
    lru_result_t       expected_q [$];
    int                errors;

    function new();
      used        = 0;
      frame_count = CNT_W'(4);
      errors      = 0;
    endfunction

    function int unsigned usable_frames();
      if (frame_count == '0) return 1;
      if (frame_count > MAX_FRAMES) return MAX_FRAMES;
      return frame_count;
    endfunction

    // any frame count write empties the stack, nothing reported
    function void set_frame_count(logic [CNT_W-1:0] value);
      frame_count = value;
      used        = 0;
    endfunction

    function void note_request(logic [PAGE_W-1:0] page);
      int          pos;
      int unsigned top;
      lru_result_t r;
      r   = '0;
      pos = -1;
      for (int i = 0; i < used; i++) begin
        if (pos < 0 && recency[i] == page) pos = i;
      end
      if (pos >= 0) begin
        r.hit = 1'b1;
        top   = pos;
      end else if (used < usable_frames()) begin
        top  = used;
        used = used + 1;
      end else begin
        // full: bottom of the stack goes out
        r.evicted_valid = 1'b1;
        r.evicted_page  = recency[used-1];
        top             = used - 1;
      end
      for (int k = top; k > 0; k--) recency[k] = recency[k-1];
      recency[0] = page;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic hit, logic ev_valid, logic [PAGE_W-1:0] ev_page);
      lru_result_t r;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (hit !== r.hit) begin
        $error("hit: expected %0d, got %0d", r.hit, hit);
        errors++;
      end
      if (ev_valid !== r.evicted_valid) begin
        $error("evicted_valid: expected %0d, got %0d", r.evicted_valid, ev_valid);
        errors++;
      end
      if (ev_page !== r.evicted_page) begin
        $error("evicted_page: expected %0d, got %0d", r.evicted_page, ev_page);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 137;
  localparam int TOTAL_ITEMS    = NUM_PHASES * PHASE_ITEMS;
  localparam int WS_MAX         = 20;
  // -1 picks a random frame count
  localparam int PHASE_COUNTS [NUM_PHASES] = '{1, 16, 2, 31, 0, 8, 17, 3, -1, -1, 15, -1};
  localparam logic [PAGE_W-1:0] WARMUP_PAGES [6] = '{10'd0, 10'd1023, 10'd0, 10'd512,
                                                      10'd341, 10'd682};

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [PAGE_W-1:0] in_page_number;
  logic              cfg_we;
  logic [CNT_W-1:0]  cfg_wdata;
  logic              out_valid;
  logic              out_hit;
  logic              out_evicted_valid;
  logic [PAGE_W-1:0] out_evicted_page;

  lru_scoreboard sb = new();
  int            idle_pct;
  int            stall_cycles;

  lru_page_replacement_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_page_number   (in_page_number),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_hit, out_evicted_valid, out_evicted_page);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // returns at the edge that takes the request
  task automatic send_request(input logic [PAGE_W-1:0] page);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_page_number <= page;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(page);
  endtask

  task automatic write_frame_count(input logic [CNT_W-1:0] value);
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_frame_count(value);
  endtask

  initial begin
    int                fc;
    int                ws_size;
    int                sel;
    int                sent;
    logic [PAGE_W-1:0] ws [WS_MAX];
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] last_page;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_page_number = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    idle_pct       = 6;
    sent           = 0;
    last_page      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset frame count of 4: fill, hit, then evict the oldest
    foreach (WARMUP_PAGES[i]) send_request(WARMUP_PAGES[i]);
    // oversize count acts as the full stack: fill all and push one past
    write_frame_count(CNT_W'(31));
    for (int k = 0; k < 17; k++) send_request(PAGE_W'(k * 61 + 7));
    // zero count acts as a single frame
    write_frame_count('0);
    send_request(10'd3);
    send_request(10'd3);
    send_request(10'd4);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      fc = (PHASE_COUNTS[ph] < 0) ? $urandom_range(0, 31) : PHASE_COUNTS[ph];
      write_frame_count(CNT_W'(fc));
      ws_size = sb.usable_frames() + $urandom_range(0, 4);
      if (ws_size > WS_MAX) ws_size = WS_MAX;
      for (int i = 0; i < ws_size; i++) ws[i] = PAGE_W'($urandom_range(0, 1023));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (sent < TOTAL_ITEMS / 3) idle_pct = 6;
        else if (sent < 2 * TOTAL_ITEMS / 3) idle_pct = 69;
        else idle_pct = 0;
        // mostly a working set as large as the stack or up to four pages larger, so
        // hits and evictions both show up
        sel = $urandom_range(0, 99);
        if (sel < 70) page = ws[$urandom_range(0, ws_size - 1)];
        else if (sel < 85) page = PAGE_W'($urandom_range(0, 1023));
        else page = last_page;
        send_request(page);
        last_page = page;
        sent++;
      end
    end

    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### lru_page_replacement_unit.f
+incdir+src
src/lru_pr_pkg.sv
src/lru_pr_cell.sv
src/lru_page_replacement_unit.sv
tb/testbench.sv
